// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the relaxation engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/lpre_pkg.sv -----
// Package of the longest path relaxation engine: constants and codes.
package lpre_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 1024;
  localparam int WEIGHT_BITS_DEF  = 32;

  localparam logic [6:0] VERTEX_COUNT_RESET = 7'd64;
  localparam logic [6:0] VPJ_RESET          = 7'd1;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_TRACE = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [1:0] KIND_PATH  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [1:0] CFG_VPJ          = 2'd1;

endpackage

// ----- rtl/lpre_if.sv -----
// Channel interfaces of the relaxation engine: request, response, config write.
interface lpre_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [5:0]        src_vertex;
  logic [5:0]        dst_vertex;
  logic signed [31:0] edge_weight;
  logic              last_edge;
  logic [5:0]        job_index;
  modport source (output valid, mode, src_vertex, dst_vertex, edge_weight, last_edge,
                  job_index, input ready);
  modport sink (input valid, mode, src_vertex, dst_vertex, edge_weight, last_edge,
                job_index, output ready);
endinterface

interface lpre_rsp_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [5:0]        from_vertex;
  logic [5:0]        to_vertex;
  logic signed [31:0] distance;
  logic              reachable;
  logic [5:0]        passes_used;
  logic              last;
  modport source (output valid, kind, from_vertex, to_vertex, distance, reachable,
                  passes_used, last, input ready);
  modport sink (input valid, kind, from_vertex, to_vertex, distance, reachable,
                passes_used, last, output ready);
endinterface

interface lpre_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/lpre_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lpre_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/longest_path_relaxation_engine_unit.sv -----
// Top level of the longest path relaxation engine: sequencer around edge and vertex RAMs.
//
//  channel | dir | transfer when        | payload
//  req     | in  | req.valid & ready    | mode, src/dst vertex, weight, last_edge, job
//  rsp     | out | rsp.valid & ready    | kind, from/to vertex, distance, reach, passes
//  cfg     | in  | cfg.valid & ready    | index (0 vertex_count, 1 vertices_per_job), data
//
// Load: decode, then edge write or a bad-edge result. Query: decode, vertex read, result;
//   a bad vertex is answered at decode. Trace: decode, then a check and a read per path edge.
// Run: a start state, then per pass a pass check and per stored edge the edge read, source
//   read, target read and write-back (a stale edge ends after the edge read, an unreached
//   source after the source read); then a final check and the done result; up to n-1 passes.
// Reset: synchronous; vertex RAM contents are masked by per-vertex valid flops,
//   which a run start also clears all at once, so there is no clearing pass.
// Stalls: req is taken only by the idle sequencer; a held rsp stalls the
//   sequencer only when it has a new result to send. cfg is always ready.
module longest_path_relaxation_engine_unit
  import lpre_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  lpre_req_if.sink  req,
  lpre_rsp_if.source rsp,
  lpre_cfg_if.sink  cfg
);

`include "assert_macros.svh"

  localparam int WB   = WEIGHT_BITS;
  localparam int EW   = (WB > 32) ? WB : 32;
  localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EL_W = $clog2(MAX_EDGES + 1);
  localparam int VA_W = $clog2(MAX_VERTICES);
  localparam int EREC = 12 + WB;     // {src, dst, cost}
  localparam int VREC = WB + 6;      // {dist, pred}
  localparam logic [EL_W-1:0] EDGE_CAP = EL_W'(MAX_EDGES);
  localparam logic [6:0]      VMAX     = 7'(MAX_VERTICES);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_RSTART = 4'd2;
  localparam logic [3:0] S_PCHK   = 4'd3;
  localparam logic [3:0] S_EREAD  = 4'd4;
  localparam logic [3:0] S_EWAIT  = 4'd5;
  localparam logic [3:0] S_UWAIT  = 4'd6;
  localparam logic [3:0] S_VWAIT  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;
  localparam logic [3:0] S_QWAIT  = 4'd9;
  localparam logic [3:0] S_TCHK   = 4'd10;
  localparam logic [3:0] S_TWAIT  = 4'd11;

  logic [3:0] state, state_next;

  // configuration
  logic [6:0] vertex_count, vpj;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RESET;
      vpj          <= VPJ_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_VERTEX_COUNT: vertex_count <= cfg.data;
        CFG_VPJ:          vpj          <= cfg.data;
        default: ;
      endcase
    end
  end

  // effective vertex count
  logic [6:0] n;
  always_comb begin
    priority if (vertex_count == 7'd0) n = 7'd1;
    else if (vertex_count > VMAX) n = VMAX;
    else n = vertex_count;
  end

  // captured request
  logic [1:0]  q_mode;
  logic [5:0]  q_src, q_dst, q_job;
  logic signed [31:0] q_w;
  logic        q_last;

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      q_mode <= req.mode;
      q_src  <= req.src_vertex;
      q_dst  <= req.dst_vertex;
      q_w    <= req.edge_weight;
      q_last <= req.last_edge;
      q_job  <= req.job_index;
    end
  end

  // weight clamp into the stored width
  logic signed [WB-1:0] w_cl;
  if (WB >= 32) begin : g_wide
    assign w_cl = WB'(q_w);
  end else begin : g_narrow
    localparam logic signed [31:0] WMAX32 = (32'sd1 <<< (WB - 1)) - 32'sd1;
    localparam logic signed [31:0] WMIN32 = -WMAX32 - 32'sd1;
    always_comb begin
      priority if (q_w > WMAX32) w_cl = WB'(WMAX32);
      else if (q_w < WMIN32) w_cl = WB'(WMIN32);
      else w_cl = WB'(q_w);
    end
  end

  // edge store
  logic            e_we, e_re;
  logic [EA_W-1:0] e_raddr;
  logic [EREC-1:0] e_rdata;
  logic [EL_W-1:0] edges_loaded, ecnt;

  lpre_ram #(.W(EREC), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (edges_loaded[EA_W-1:0]),
    .wdata ({q_src, q_dst, w_cl}),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  // vertex store; valid flops mask entries not written since the run started
  logic            v_we, v_re;
  logic [VA_W-1:0] v_waddr, v_raddr;
  logic [VREC-1:0] v_wdata, v_rdata;
  logic [MAX_VERTICES-1:0] vld;
  logic            vld_q, a0_q;

  lpre_ram #(.W(VREC), .DEPTH(MAX_VERTICES)) u_vert_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .re    (v_re),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  always_ff @(posedge clk) begin
    if (v_re) begin
      vld_q <= vld[v_raddr];
      a0_q  <= (v_raddr == '0);
    end
  end

  logic signed [WB-1:0] rd_dist;
  logic [5:0]           rd_pred;
  logic                 rd_reach;
  logic signed [EW-1:0] rd_ext;
  assign rd_dist  = vld_q ? signed'(v_rdata[VREC-1:6]) : '0;
  assign rd_pred  = vld_q ? v_rdata[5:0] : 6'd0;
  assign rd_reach = vld_q | a0_q;
  assign rd_ext   = EW'(rd_dist);

  // run state
  logic [5:0] pc;
  logic       chg;
  logic [5:0] eu, ev;
  logic signed [WB-1:0] ew_q, ud_q;

  // saturating sum
  logic signed [WB:0]   sum_w;
  logic signed [WB-1:0] sum_s;
  assign sum_w = {ud_q[WB-1], ud_q} + {ew_q[WB-1], ew_q};
  always_comb begin
    unique case (sum_w[WB:WB-1])
      2'b01:   sum_s = {1'b0, {(WB-1){1'b1}}};
      2'b10:   sum_s = {1'b1, {(WB-1){1'b0}}};
      default: sum_s = sum_w[WB-1:0];
    endcase
  end
  logic relax_ok;
  assign relax_ok = !rd_reach || (sum_s > rd_dist);

  // trace
  logic [13:0] tstart;
  logic [5:0]  cur, len;
  logic        t_last;
  assign tstart = (14'(q_job) + 14'd1) * 14'(vpj);
  assign t_last = (rd_pred == 6'd0) || (({1'b0, len} + 7'd1) >= (n - 7'd1));

  // edge decode checks
  logic bad_edge, bad_query;
  assign bad_edge  = ({1'b0, q_src} >= n) || ({1'b0, q_dst} >= n) ||
                     (edges_loaded >= EDGE_CAP);
  assign bad_query = ({1'b0, q_src} >= n);

  // output register
  logic out_free, o_ld;
  logic [1:0] o_kind;
  logic [5:0] o_from, o_to, o_pass;
  logic signed [31:0] o_dist;
  logic o_reach, o_last;
  assign out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (o_ld) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ld) begin
      rsp.kind        <= o_kind;
      rsp.from_vertex <= o_from;
      rsp.to_vertex   <= o_to;
      rsp.distance    <= o_dist;
      rsp.reachable   <= o_reach;
      rsp.passes_used <= o_pass;
      rsp.last        <= o_last;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    e_we = 1'b0; e_re = 1'b0; e_raddr = ecnt[EA_W-1:0];
    v_we = 1'b0; v_re = 1'b0;
    v_waddr = ev[VA_W-1:0]; v_raddr = q_src[VA_W-1:0];
    v_wdata = {sum_s, eu};
    o_ld = 1'b0; o_kind = KIND_BAD; o_from = '0; o_to = '0; o_dist = '0;
    o_reach = 1'b0; o_pass = '0; o_last = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_DEC;
      end
      S_DEC: begin
        unique case (q_mode)
          MODE_LOAD: begin
            if (!bad_edge) begin
              e_we = 1'b1;
              state_next = q_last ? S_RSTART : S_IDLE;
            end else if (out_free) begin
              o_ld = 1'b1; o_from = q_src; o_to = q_dst; o_last = !q_last;
              state_next = q_last ? S_RSTART : S_IDLE;
            end
          end
          MODE_QUERY: begin
            if (bad_query) begin
              if (out_free) begin
                o_ld = 1'b1; o_to = q_src; state_next = S_IDLE;
              end
            end else begin
              v_re = 1'b1; state_next = S_QWAIT;
            end
          end
          MODE_TRACE: begin
            if (tstart >= 14'(n)) begin
              if (out_free) begin
                o_ld = 1'b1; o_to = tstart[5:0]; state_next = S_IDLE;
              end
            end else begin
              state_next = S_TCHK;
            end
          end
          MODE_NONE: state_next = S_IDLE;
          default: state_next = S_IDLE;
        endcase
      end
      S_RSTART: state_next = S_PCHK;
      S_PCHK: begin
        state_next = (chg && (({1'b0, pc} + 7'd1) < n)) ? S_EREAD : S_DONE;
      end
      S_EREAD: begin
        if (ecnt >= edges_loaded) begin
          state_next = S_PCHK;
        end else begin
          e_re = 1'b1; state_next = S_EWAIT;
        end
      end
      S_EWAIT: begin
        v_raddr = e_rdata[EREC-6 +: VA_W];
        if (({1'b0, e_rdata[EREC-1:EREC-6]} >= n) ||
            ({1'b0, e_rdata[EREC-7:WB]} >= n)) begin
          state_next = S_EREAD;
        end else begin
          v_re = 1'b1; state_next = S_UWAIT;
        end
      end
      S_UWAIT: begin
        v_raddr = ev[VA_W-1:0];
        if (rd_reach) begin
          v_re = 1'b1; state_next = S_VWAIT;
        end else begin
          state_next = S_EREAD;
        end
      end
      S_VWAIT: begin
        v_we = relax_ok;
        state_next = S_EREAD;
      end
      S_DONE: begin
        if (out_free) begin
          o_ld = 1'b1; o_kind = KIND_DONE; o_pass = pc; state_next = S_IDLE;
        end
      end
      S_QWAIT: begin
        if (out_free) begin
          o_ld = 1'b1; o_kind = KIND_QUERY; o_from = rd_pred; o_to = q_src;
          o_dist = rd_ext[31:0]; o_reach = rd_reach; state_next = S_IDLE;
        end
      end
      S_TCHK: begin
        v_raddr = cur[VA_W-1:0];
        if ((cur != 6'd0) && ({1'b0, len} < (n - 7'd1))) begin
          v_re = 1'b1; state_next = S_TWAIT;
        end else begin
          state_next = S_IDLE;   // walk of no edges
        end
      end
      S_TWAIT: begin
        if (out_free) begin
          o_ld = 1'b1; o_kind = KIND_PATH; o_from = rd_pred; o_to = cur;
          o_dist = rd_ext[31:0]; o_reach = rd_reach; o_last = t_last;
          state_next = t_last ? S_IDLE : S_TCHK;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      edges_loaded <= '0;
      vld          <= '0;
      pc           <= '0;
      chg          <= 1'b0;
    end else begin
      state <= state_next;
      if (e_we) edges_loaded <= edges_loaded + EL_W'(1);
      if (state == S_RSTART) begin
        vld <= '0; pc <= '0; chg <= 1'b1;
      end
      if (state == S_PCHK && state_next == S_EREAD) begin
        chg <= 1'b0; pc <= pc + 6'd1;
      end
      if (v_we) begin
        vld[v_waddr] <= 1'b1; chg <= 1'b1;
      end
      if (state == S_DONE && o_ld) edges_loaded <= '0;
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (state == S_PCHK) ecnt <= '0;
    if (e_re) ecnt <= ecnt + EL_W'(1);
    if (state == S_EWAIT) begin
      eu   <= e_rdata[EREC-1:EREC-6];
      ev   <= e_rdata[EREC-7:WB];
      ew_q <= signed'(e_rdata[WB-1:0]);
    end
    if (state == S_UWAIT) ud_q <= rd_dist;
    if (state == S_DEC) begin
      cur <= tstart[5:0]; len <= '0;
    end
    if (state == S_TWAIT && o_ld) begin
      cur <= rd_pred; len <= len + 6'd1;
    end
  end

  logic relaxing;
  assign relaxing = (state == S_EREAD) || (state == S_VWAIT);

  `ASSERT_CLK(a_pass_bound, relaxing |-> ({1'b0, pc} < n), "pass count beyond limit")
  `ASSERT_NEVER(a_edge_bound, edges_loaded > EDGE_CAP, "edge count beyond capacity")
  `ASSERT_NEVER(a_out_overrun, o_ld && rsp.valid && !rsp.ready, "held result overwritten")
  `ASSERT_CLK(a_vwrite_src, v_we |-> (state == S_VWAIT) && relax_ok, "stray vertex write")

endmodule
